// File: rtl/user_permission_table_assert.svh
// Assertion macros used by the checker file of the permission table.
`ifndef USER_PERMISSION_TABLE_ASSERT_SVH
`define USER_PERMISSION_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UPT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UPT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/upt_pkg.sv
// Package with the types and constants of the permission table.
`default_nettype none

package upt_pkg;

    // Request codes as they arrive on the input item.
    typedef enum logic [2:0] {
        REQ_ADD    = 3'd0,
        REQ_REMOVE = 3'd1,
        REQ_GRANT  = 3'd2,
        REQ_REVOKE = 3'd3,
        REQ_CHECK  = 3'd4
    } req_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_ENABLE = 2'd1;

    // Reset value of the slot limit register.
    localparam logic [6:0] LIMIT_RESET = 7'd64;

    // Depth of the queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // A classified item as it travels from front to back.
    typedef struct packed {
        req_t        req;
        logic        ok;
        logic [31:0] uid;
        logic [31:0] perm;
    } item_t;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MATCH,
        BK_PICK,
        BK_EXEC
    } back_state_t;

endpackage

`default_nettype wire

// File: rtl/user_permission_table.sv
// Top level of the user permission table.
//
//   Channel   Handshake            Signals
//   request   start, busy          req_type, user_id, permission
//   result    done (one cycle)     status, access_allowed, active_count
//   config    cfg_write            cfg_index, cfg_data
//
// An item passes through the back-end steps in order (queue pop, id compare over
// all slots, slot selection with mask read, execute), and its result is strobed
// on done in the cycle after execution. The back-end sequencer takes a new item
// only once it is through with the last one. A two-item queue lets the front
// take items while the back end works; busy is high while that queue is full.
// Reset clears the valid bits, the count and the registers at once; no clearing
// pass follows. Results cannot be stalled.
`default_nettype none

module user_permission_table #(
    parameter int MAX_ENTRIES = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  req_type,
    input  wire logic [31:0] user_id,
    input  wire logic [31:0] permission,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [6:0]  cfg_data,
    output logic             done,
    output logic             status,
    output logic             access_allowed,
    output logic [6:0]       active_count
);

    import upt_pkg::*;

    localparam int SAT_LIMIT = (MAX_ENTRIES < 127) ? MAX_ENTRIES : 127;

    logic [6:0] limit_val_reg;
    logic       enable_reg;
    logic [6:0] slot_limit;
    logic       q_full;
    logic       q_empty;
    logic       q_push;
    logic       q_pop;
    item_t      push_item;
    item_t      pop_item;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_val_reg <= LIMIT_RESET;
            enable_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_LIMIT:  limit_val_reg <= cfg_data;
                    CFG_ENABLE: enable_reg    <= cfg_data[0];
                    default:
                    begin
                        // Indexes with no register behind them are ignored.
                    end
                endcase
            end
        end
    end

    // The limit saturates at the table size.
    assign slot_limit = ({25'd0, limit_val_reg} > 32'(SAT_LIMIT)) ? 7'(SAT_LIMIT)
                                                                  : limit_val_reg;

    upt_front u_front (
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .user_id      (user_id),
        .permission   (permission),
        .table_enable (enable_reg),
        .q_full       (q_full),
        .push         (q_push),
        .push_item    (push_item)
    );

    upt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    upt_back #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_item         (pop_item),
        .q_pop          (q_pop),
        .slot_limit     (slot_limit),
        .done           (done),
        .status         (status),
        .access_allowed (access_allowed),
        .active_count   (active_count)
    );

endmodule

`default_nettype wire

// File: rtl/upt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module upt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/upt_front.sv
// Front end: accepts request items and classifies them before queueing.
`default_nettype none

module upt_front (
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [2:0]           req_type,
    input  wire logic [31:0]          user_id,
    input  wire logic [31:0]          permission,
    input  wire logic                 table_enable,
    input  wire logic                 q_full,
    output logic                      push,
    output upt_pkg::item_t            push_item
);

    import upt_pkg::*;

    logic known_req;
    logic needs_perm;

    // An item is taken whenever the queue has room.
    assign busy = q_full;
    assign push = start && !q_full;

    // Classify the request: anything rejected here is only reported as an error.
    always_comb
    begin
        known_req  = req_type inside {REQ_ADD, REQ_REMOVE, REQ_GRANT, REQ_REVOKE, REQ_CHECK};
        needs_perm = req_type inside {REQ_GRANT, REQ_REVOKE, REQ_CHECK};
        push_item.req  = req_t'(req_type);
        push_item.uid  = user_id;
        push_item.perm = permission;
        push_item.ok   = table_enable && (user_id != 32'd0) && known_req &&
                         !(needs_perm && (permission == 32'd0));
    end

endmodule

`default_nettype wire

// File: rtl/upt_queue.sv
// Short queue of classified items between the front and back ends.
`default_nettype none

module upt_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire upt_pkg::item_t push_item,
    input  wire logic           pop,
    output upt_pkg::item_t      pop_item,
    output logic                full,
    output logic                empty
);

    import upt_pkg::*;

    item_t                slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;

    assign full     = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = slot_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Item storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/upt_back.sv
// Back end: matches ids across the table, updates entries and reports results.
`default_nettype none

module upt_back #(
    parameter int MAX_ENTRIES = 64
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_empty,
    input  wire upt_pkg::item_t q_item,
    output logic                q_pop,
    input  wire logic [6:0]     slot_limit,
    output logic                done,
    output logic                status,
    output logic                access_allowed,
    output logic [6:0]          active_count
);

    import upt_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    back_state_t              state_reg;
    back_state_t              state_next;
    item_t                    item_reg;
    logic [MAX_ENTRIES-1:0]   valid_reg;
    logic [31:0]              id_reg [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]   in_range;
    logic [MAX_ENTRIES-1:0]   match_reg;
    logic [MAX_ENTRIES-1:0]   free_reg;
    logic [IDX_W-1:0]         hit_idx;
    logic                     hit_any;
    logic [IDX_W-1:0]         free_idx;
    logic                     free_any;
    logic [IDX_W-1:0]         hit_idx_reg;
    logic                     hit_any_reg;
    logic [IDX_W-1:0]         free_idx_reg;
    logic                     free_any_reg;
    logic [6:0]               active_reg;
    logic [6:0]               active_next;
    logic                     done_reg;
    logic                     status_reg;
    logic                     allow_reg;
    logic [6:0]               count_out_reg;
    logic                     do_add;
    logic                     do_remove;
    logic                     do_grant;
    logic                     do_revoke;
    logic                     do_check;
    logic                     allow;
    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    logic [31:0]              ram_wdata;
    logic [31:0]              ram_rdata;

    // Slots at or above the limit are neither searched nor allocated.
    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            in_range[i] = (32'(i) < {25'd0, slot_limit});
        end
    end

    // Lowest matching slot and lowest free slot.
    always_comb
    begin
        hit_idx  = '0;
        hit_any  = 1'b0;
        free_idx = '0;
        free_any = 1'b0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                hit_idx = IDX_W'(i);
                hit_any = 1'b1;
            end
            if (free_reg[i])
            begin
                free_idx = IDX_W'(i);
                free_any = 1'b1;
            end
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = BK_MATCH;
                end
            end
            BK_MATCH: state_next = BK_PICK;
            BK_PICK:  state_next = BK_EXEC;
            BK_EXEC:  state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    // Sequencer outputs and the actions of the execute step.
    always_comb
    begin
        q_pop     = 1'b0;
        do_add    = 1'b0;
        do_remove = 1'b0;
        do_grant  = 1'b0;
        do_revoke = 1'b0;
        do_check  = 1'b0;
        allow     = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                q_pop = !q_empty;
            end
            BK_EXEC:
            begin
                if (item_reg.ok)
                begin
                    case (item_reg.req)
                        REQ_ADD:
                        begin
                            do_add = !hit_any_reg && (active_reg < slot_limit) &&
                                     free_any_reg;
                        end
                        REQ_REMOVE: do_remove = hit_any_reg;
                        REQ_GRANT:  do_grant  = hit_any_reg;
                        REQ_REVOKE: do_revoke = hit_any_reg;
                        REQ_CHECK:
                        begin
                            do_check = 1'b1;
                            allow    = hit_any_reg &&
                                       ((ram_rdata & item_reg.perm) == item_reg.perm);
                        end
                        default: do_check = 1'b0;
                    endcase
                end
            end
            default: q_pop = 1'b0;
        endcase
    end

    // Active entry count.
    always_comb
    begin
        active_next = active_reg;
        if (do_add)
        begin
            active_next = active_reg + 7'd1;
        end
        else if (do_remove && (active_reg != 7'd0))
        begin
            active_next = active_reg - 7'd1;
        end
    end

    // Mask store writes: a new entry starts empty, grant sets bits, revoke clears them.
    always_comb
    begin
        ram_we    = do_add || do_grant || do_revoke;
        ram_waddr = do_add ? free_idx_reg : hit_idx_reg;
        if (do_add)
        begin
            ram_wdata = 32'd0;
        end
        else if (do_grant)
        begin
            ram_wdata = ram_rdata | item_reg.perm;
        end
        else
        begin
            ram_wdata = ram_rdata & ~item_reg.perm;
        end
    end

    // Mask store, read at the matched slot during slot selection, ahead of execution.
    upt_ram #(
        .WIDTH (32),
        .DEPTH (MAX_ENTRIES)
    ) u_mask_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (hit_idx),
        .rdata (ram_rdata)
    );

    // Control state, valid bits, count and result item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            valid_reg     <= '0;
            active_reg    <= 7'd0;
            done_reg      <= 1'b0;
            status_reg    <= 1'b0;
            allow_reg     <= 1'b0;
            count_out_reg <= 7'd0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            done_reg   <= (state_reg == BK_EXEC);
            if (do_add)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
            if (do_remove)
            begin
                valid_reg[hit_idx_reg] <= 1'b0;
            end
            if (state_reg == BK_EXEC)
            begin
                status_reg    <= !(do_add || do_remove || do_grant || do_revoke || do_check);
                allow_reg     <= allow;
                count_out_reg <= active_next;
            end
        end
    end

    // Item, compare results, slot indexes and stored ids.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_item;
        end
        if (state_reg == BK_MATCH)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                match_reg[i] <= valid_reg[i] && in_range[i] && (id_reg[i] == item_reg.uid);
                free_reg[i]  <= !valid_reg[i] && in_range[i];
            end
        end
        if (state_reg == BK_PICK)
        begin
            hit_idx_reg  <= hit_idx;
            hit_any_reg  <= hit_any;
            free_idx_reg <= free_idx;
            free_any_reg <= free_any;
        end
        if (do_add)
        begin
            id_reg[free_idx_reg] <= item_reg.uid;
        end
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign access_allowed = allow_reg;
    assign active_count   = count_out_reg;

endmodule

`default_nettype wire

// File: rtl/upt_checker.sv
// Port-level checker for the permission table, bound to the top level.
`default_nettype none

`include "user_permission_table_assert.svh"

module upt_checker #(
    parameter int MAX_ENTRIES = 64
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        done,
    input wire logic        status,
    input wire logic        access_allowed,
    input wire logic [6:0]  active_count
);

    // An allowed check is always a successful one.
    `UPT_ASSERT_IMP(a_allow_ok, clk, rst_n, done && access_allowed, !status, "allowed with error status")

    // Each item occupies the back end through all its sequencer steps, so strobes never touch.
    `UPT_ASSERT_NXT(a_done_gap, clk, rst_n, done, !done, "result strobes back to back")

    // The count never exceeds the table size.
    `UPT_ASSERT_IMP(a_count_max, clk, rst_n, done, {25'd0, active_count} <= 32'(MAX_ENTRIES), "active count above table size")

endmodule

bind user_permission_table upt_checker #(
    .MAX_ENTRIES (MAX_ENTRIES)
) u_upt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .done           (done),
    .status         (status),
    .access_allowed (access_allowed),
    .active_count   (active_count)
);

`default_nettype wire

// File: sim/tb_user_permission_table.sv
// Self-checking testbench for the user permission table: directed and random requests.
module tb_user_permission_table;

    import upt_pkg::*;

    localparam int SLOTS = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int POOL_SIZE = 96;

    // Register indexes with no register behind them.
    localparam logic [1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [1:0] CFG_SPARE_HI = 2'd3;

    // Request codes outside the defined set.
    localparam logic [2:0] REQ_UNKNOWN_LO = 3'd5;
    localparam logic [2:0] REQ_UNKNOWN_HI = 3'd7;

    localparam logic [31:0] ID_ALL_ONES = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] uid;
        logic [31:0] perm;
    } request_t;

    typedef struct packed {
        logic       status;
        logic       allowed;
        logic [6:0] count;
    } reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  req_type = '0;
    logic [31:0] user_id = '0;
    logic [31:0] permission = '0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [6:0]  cfg_data = '0;
    logic        done;
    logic        status;
    logic        access_allowed;
    logic [6:0]  active_count;

    // Requests waiting to be offered and replies still to come back.
    request_t queued_requests[$];
    reply_t   predicted_replies[$];
    logic [31:0] id_pool[$];

    int          idle_pct = 0;
    int          errors = 0;
    int unsigned cycle_count = 0;

    // Mirror of the table contents and registers.
    logic        slot_used[SLOTS];
    logic [31:0] slot_user[SLOTS];
    logic [31:0] slot_perms[SLOTS];
    logic [6:0]  user_total;
    logic [6:0]  limit_reg;
    logic        table_on;

    user_permission_table #(
        .MAX_ENTRIES(SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req_type(req_type),
        .user_id(user_id),
        .permission(permission),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .done(done),
        .status(status),
        .access_allowed(access_allowed),
        .active_count(active_count)
    );

    always #10 clk = ~clk;

    // Number of slots searched and allocated, saturated at the table size.
    function automatic int search_span();
        return (limit_reg > SLOTS) ? SLOTS : int'(limit_reg);
    endfunction

    function automatic int lookup_slot(logic [31:0] uid);
        int span;
        span = search_span();
        for (int i = 0; i < span; i++) begin
            if (slot_used[i] && slot_user[i] == uid) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Applies one request to the mirrored table and returns the reply it should give.
    function automatic reply_t apply_request(request_t rq);
        reply_t rp;
        int     hit;
        int     span;
        rp.status = 1'b1;
        rp.allowed = 1'b0;
        span = search_span();
        if (table_on && rq.uid != 0 && rq.kind <= REQ_CHECK
            && !(rq.kind >= REQ_GRANT && rq.perm == 0)) begin
            hit = lookup_slot(rq.uid);
            case (rq.kind)
                REQ_ADD:
                begin
                    if (hit < 0 && user_total < span) begin
                        // Take the lowest free slot below the limit.
                        for (int i = 0; i < span; i++) begin
                            if (rp.status && !slot_used[i]) begin
                                slot_used[i] = 1'b1;
                                slot_user[i] = rq.uid;
                                slot_perms[i] = '0;
                                user_total = user_total + 7'd1;
                                rp.status = 1'b0;
                            end
                        end
                    end
                end
                REQ_REMOVE:
                begin
                    if (hit >= 0) begin
                        slot_used[hit] = 1'b0;
                        slot_user[hit] = '0;
                        slot_perms[hit] = '0;
                        if (user_total != 0) begin
                            user_total = user_total - 7'd1;
                        end
                        rp.status = 1'b0;
                    end
                end
                REQ_GRANT:
                begin
                    if (hit >= 0) begin
                        slot_perms[hit] = slot_perms[hit] | rq.perm;
                        rp.status = 1'b0;
                    end
                end
                REQ_REVOKE:
                begin
                    if (hit >= 0) begin
                        slot_perms[hit] = slot_perms[hit] & ~rq.perm;
                        rp.status = 1'b0;
                    end
                end
                REQ_CHECK:
                begin
                    rp.status = 1'b0;
                    if (hit >= 0 && (slot_perms[hit] & rq.perm) == rq.perm) begin
                        rp.allowed = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        rp.count = user_total;
        return rp;
    endfunction

    function automatic logic [31:0] fresh_id();
        logic [31:0] id;
        id = $urandom;
        while (id == 0) begin
            id = $urandom;
        end
        return id;
    endfunction

    // Mostly narrow masks so that checks on granted bits often succeed.
    function automatic logic [31:0] random_perm();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            return '0;
        end else if (pick < 10) begin
            return '1;
        end else if (pick < 45) begin
            return 32'd1 << $urandom_range(0, 3);
        end else if (pick < 70) begin
            return 32'($urandom_range(0, 255)) << (8 * $urandom_range(0, 3));
        end
        return $urandom;
    endfunction

    // Mostly well-formed requests on known ids, with some noise.
    function automatic request_t random_request(int span);
        request_t rq;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 24) begin
            rq.kind = REQ_ADD;
        end else if (pick < 36) begin
            rq.kind = REQ_REMOVE;
        end else if (pick < 58) begin
            rq.kind = REQ_GRANT;
        end else if (pick < 72) begin
            rq.kind = REQ_REVOKE;
        end else if (pick < 96) begin
            rq.kind = REQ_CHECK;
        end else if (pick < 98) begin
            rq.kind = 3'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI));
        end else begin
            rq.kind = 3'($urandom_range(REQ_ADD, REQ_CHECK));
        end
        if (pick >= 98) begin
            rq.uid = '0;
        end else if ($urandom_range(0, 99) < 92) begin
            rq.uid = id_pool[$urandom_range(0, span - 1)];
        end else begin
            rq.uid = fresh_id();
        end
        rq.perm = random_perm();
        return rq;
    endfunction

    task automatic push_req(input logic [2:0] kind, input logic [31:0] uid,
                            input logic [31:0] perm);
        request_t rq;
        rq.kind = kind;
        rq.uid = uid;
        rq.perm = perm;
        queued_requests.push_back(rq);
    endtask

    // Waits until every item has been taken and every reply has come back.
    task automatic drain();
        @(negedge clk);
        while (queued_requests.size() != 0 || start || predicted_replies.size() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [6:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (index == CFG_LIMIT) begin
            limit_reg = value;
        end else if (index == CFG_ENABLE) begin
            table_on = value[0];
        end
        @(negedge clk);
    endtask

    task automatic run_random(input int count, input int span, input int idle);
        idle_pct = idle;
        repeat (count) queued_requests.push_back(random_request(span));
        drain();
    endtask

    // Request driver: predicts each item as it is taken and offers the next one.
    always @(posedge clk) begin
        if (rst_n) begin
            if (start && !busy) begin
                predicted_replies.push_back(apply_request(queued_requests.pop_front()));
            end
            if (!(start && busy)) begin
                if (queued_requests.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    start <= 1'b1;
                    req_type <= queued_requests[0].kind;
                    user_id <= queued_requests[0].uid;
                    permission <= queued_requests[0].perm;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Reply monitor: compares each strobed reply with the oldest prediction.
    always @(posedge clk) begin : reply_check
        reply_t want;
        if (rst_n && done) begin
            if (predicted_replies.size() == 0) begin
                $error("unexpected reply: status %0d, access_allowed %0d, active_count %0d",
                       status, access_allowed, active_count);
                errors++;
            end else begin
                want = predicted_replies.pop_front();
                if (status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    errors++;
                end
                if (access_allowed !== want.allowed) begin
                    $error("access_allowed: expected %0d, got %0d", want.allowed,
                           access_allowed);
                    errors++;
                end
                if (active_count !== want.count) begin
                    $error("active_count: expected %0d, got %0d", want.count, active_count);
                    errors++;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            slot_used[i] = 1'b0;
            slot_user[i] = '0;
            slot_perms[i] = '0;
        end
        user_total = '0;
        limit_reg = LIMIT_RESET;
        table_on = 1'b0;
        for (int i = 0; i < POOL_SIZE; i++) begin
            id_pool.push_back(fresh_id());
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The table comes out of reset disabled, so everything fails.
        push_req(REQ_ADD, 32'd5, 32'd0);
        push_req(REQ_CHECK, 32'd5, 32'd1);
        drain();

        // Basic operations, duplicates, zero id, zero permission and unknown codes.
        write_register(CFG_ENABLE, 7'd1);
        push_req(REQ_ADD, 32'd0, 32'd0);
        push_req(REQ_ADD, ID_ALL_ONES, 32'd0);
        push_req(REQ_ADD, ID_ALL_ONES, $urandom);
        push_req(REQ_ADD, 32'd1, 32'd0);
        push_req(REQ_GRANT, ID_ALL_ONES, 32'd0);
        push_req(REQ_CHECK, ID_ALL_ONES, 32'd0);
        push_req(REQ_GRANT, ID_ALL_ONES, '1);
        push_req(REQ_CHECK, ID_ALL_ONES, 32'h8000_0001);
        push_req(REQ_REVOKE, ID_ALL_ONES, 32'h0000_FFFF);
        push_req(REQ_CHECK, ID_ALL_ONES, 32'h0000_0001);
        push_req(REQ_CHECK, ID_ALL_ONES, 32'hFFFF_0000);
        push_req(REQ_GRANT, 32'd1, 32'h5555_5555);
        push_req(REQ_CHECK, 32'd1, 32'h0000_0005);
        push_req(REQ_UNKNOWN_HI, 32'd1, 32'd1);
        push_req(REQ_UNKNOWN_LO, 32'd1, 32'd1);
        push_req(REQ_REMOVE, 32'd1, '1);
        push_req(REQ_REMOVE, 32'd1, 32'd0);
        push_req(REQ_GRANT, 32'd1, 32'd1);
        push_req(REQ_REVOKE, 32'd1, 32'd1);
        push_req(REQ_CHECK, 32'd1, 32'd1);
        drain();

        // With a zero limit nothing is searched and nothing can be added.
        write_register(CFG_LIMIT, 7'd0);
        push_req(REQ_ADD, 32'd2, 32'd0);
        push_req(REQ_CHECK, ID_ALL_ONES, 32'h0001_0000);
        drain();

        // The single slot is already taken, so the count is at the limit.
        write_register(CFG_LIMIT, 7'd1);
        push_req(REQ_ADD, 32'd3, 32'd0);
        push_req(REQ_CHECK, ID_ALL_ONES, 32'h0001_0000);
        drain();

        // Writes to unused indexes must leave the registers alone.
        write_register(CFG_SPARE_LO, 7'd0);
        write_register(CFG_SPARE_HI, 7'd0);

        // Fill the whole table, then push past full.
        write_register(CFG_LIMIT, 7'd64);
        idle_pct = 0;
        for (int i = 0; i < 66; i++) begin
            push_req(REQ_ADD, id_pool[i], $urandom);
        end
        drain();
        run_random(90, POOL_SIZE, 55);

        // Limit lowered below the occupied slots: the upper entries stay counted.
        write_register(CFG_LIMIT, 7'd10);
        run_random(60, POOL_SIZE, 19);

        // Empty most of the table again.
        write_register(CFG_LIMIT, 7'd64);
        idle_pct = 0;
        for (int i = 0; i < 70; i++) begin
            push_req(REQ_REMOVE, id_pool[i], $urandom);
        end
        drain();

        // A small table on a small set of ids keeps hitting the full case.
        write_register(CFG_LIMIT, 7'd5);
        run_random(100, 8, 55);

        // A limit above the table size saturates.
        write_register(CFG_LIMIT, 7'd127);
        run_random(100, 24, 19);

        write_register(CFG_ENABLE, 7'd0);
        run_random(30, 24, 0);

        write_register(CFG_ENABLE, 7'd1);
        write_register(CFG_LIMIT, 7'd0);
        run_random(30, 24, 55);

        write_register(CFG_LIMIT, 7'd64);
        run_random(90, 40, 0);

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
